>>> rtl/trq_pkg.sv
// Shared types, codes and sizes of the triggered release queue.
package trq_pkg;

  localparam int DEPTH = 16;
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam int IN_TDATA_W  = 296;
  localparam int OUT_TDATA_W = 168;

  typedef enum logic [1:0] {
    FN_ENQUEUE  = 2'd0,
    FN_NEWBLOCK = 2'd1,
    FN_CANCEL   = 2'd2
  } func_e;

  typedef enum logic [3:0] {
    ST_QUEUED     = 4'd0,
    ST_NO_TRIGGER = 4'd1,
    ST_BOTH       = 4'd2,
    ST_NEGATIVE   = 4'd3,
    ST_DUPLICATE  = 4'd4,
    ST_FULL       = 4'd5,
    ST_CANCELLED  = 4'd6,
    ST_NOT_FOUND  = 4'd7,
    ST_RELEASED   = 4'd8,
    ST_NONE_READY = 4'd9
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_FIN,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [63:0] trigger;
    logic        by_height;
    logic [31:0] handle;
    logic [63:0] key;
  } slot_t;

  typedef struct packed {
    logic key_match;
    logic ready;
  } cmp_res_t;

endpackage

>>> rtl/triggered_release_queue.sv
// Top level of the triggered release queue: sequencer, entry table and output register.
//
// Use: one operation arrives per slave transaction, func in tuser: enqueue,
// new block or cancel. Each operation gives result transactions on the
// master side, status in tuser, the final one marked by tlast. Enqueue and
// cancel give one result; a new block gives one per released entry in queue
// order, or a single "none ready" result. func 3 is taken and gives nothing.
// The block takes one operation at a time; s_axis_tready_o is low while an
// operation is in progress.
// Sequencing: the sequencer walks the table through the shared compare unit,
// one stored entry at a time: RAM read in S_READ, then compare and compaction
// write in S_EVAL.
// A rejected enqueue that fails its trigger checks skips the walk and goes straight to S_RESP.
// Stalls: the result register holds its transaction while m_axis_tready_i is
// low; the scan waits on it and nothing is lost.
// Reset: clears the entry count and the control state; table contents are
// left as they are and are never read before being written.
module triggered_release_queue (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // entry_key, entry_handle, has_height, has_time, height_value, time_value,
  // chain_height, chain_time, zero pad
  input  logic [trq_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // func
  input  logic [1:0]                         s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // out_key, out_handle, out_by_height, out_trigger, zero pad
  output logic [trq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  // status
  output logic [3:0]                         m_axis_tuser_o,
  output logic                               m_axis_tlast_o
);

  trq_pkg::state_e    state_q, state_d;
  logic [trq_pkg::CW-1:0] idx_q, idx_d, wr_q, wr_d, count_q, count_d;
  logic               found_q, found_d;
  logic               pend_valid_q, pend_valid_d;
  trq_pkg::slot_t     pend_q, pend_d;
  logic [1:0]         func_q, func_d;
  logic [63:0]        key_q, key_d;
  logic [31:0]        handle_q, handle_d;
  logic               by_height_q, by_height_d;
  logic [63:0]        trig_q, trig_d;
  logic [31:0]        ch_q, ch_d;
  logic [63:0]        ct_q, ct_d;
  trq_pkg::status_e   status_q, status_d;

  logic               out_valid_q, out_valid_d;
  trq_pkg::status_e   out_status_q, out_status_d;
  trq_pkg::slot_t     out_slot_q, out_slot_d;
  logic               out_last_q, out_last_d;
  logic               out_load, out_free;

  logic               ram_we;
  logic [trq_pkg::IW-1:0] ram_waddr;
  trq_pkg::slot_t     ram_wdata, ram_rdata;
  trq_pkg::cmp_res_t  cmp_res;

  logic               in_accept;
  logic               in_hh, in_ht, in_neg;
  logic [31:0]        in_hval;
  logic [63:0]        in_tval;

  assign in_hh   = s_axis_tdata_i[96];
  assign in_ht   = s_axis_tdata_i[97];
  assign in_hval = s_axis_tdata_i[129:98];
  assign in_tval = s_axis_tdata_i[193:130];
  assign in_neg  = (in_hh && in_hval[31]) || (in_ht && in_tval[63]);

  assign s_axis_tready_o = (state_q == trq_pkg::S_IDLE);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  trq_ram #(
    .WIDTH ($bits(trq_pkg::slot_t)),
    .DEPTH (trq_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q[trq_pkg::IW-1:0]),
    .rdata_o (ram_rdata)
  );

  trq_cmp u_cmp (
    .key_i          (key_q),
    .chain_height_i (ch_q),
    .chain_time_i   (ct_q),
    .slot_i         (ram_rdata),
    .res_o          (cmp_res)
  );

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    wr_d         = wr_q;
    count_d      = count_q;
    found_d      = found_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    func_d       = func_q;
    key_d        = key_q;
    handle_d     = handle_q;
    by_height_d  = by_height_q;
    trig_d       = trig_q;
    ch_d         = ch_q;
    ct_d         = ct_q;
    status_d     = status_q;
    out_load     = 1'b0;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_last_d   = out_last_q;
    ram_we       = 1'b0;
    ram_waddr    = wr_q[trq_pkg::IW-1:0];
    ram_wdata    = ram_rdata;

    unique case (state_q)
      trq_pkg::S_IDLE: begin
        if (in_accept) begin
          func_d       = s_axis_tuser_i;
          key_d        = s_axis_tdata_i[63:0];
          handle_d     = s_axis_tdata_i[95:64];
          by_height_d  = in_hh;
          trig_d       = in_hh ? {{32{in_hval[31]}}, in_hval} : in_tval;
          ch_d         = s_axis_tdata_i[225:194];
          ct_d         = s_axis_tdata_i[289:226];
          idx_d        = '0;
          wr_d         = '0;
          found_d      = 1'b0;
          pend_valid_d = 1'b0;
          unique case (s_axis_tuser_i)
            trq_pkg::FN_ENQUEUE: begin
              priority if (!in_hh && !in_ht) begin
                status_d = trq_pkg::ST_NO_TRIGGER;
                state_d  = trq_pkg::S_RESP;
              end else if (in_hh && in_ht) begin
                status_d = trq_pkg::ST_BOTH;
                state_d  = trq_pkg::S_RESP;
              end else if (in_neg) begin
                status_d = trq_pkg::ST_NEGATIVE;
                state_d  = trq_pkg::S_RESP;
              end else begin
                state_d  = trq_pkg::S_READ;
              end
            end
            trq_pkg::FN_NEWBLOCK,
            trq_pkg::FN_CANCEL: state_d = trq_pkg::S_READ;
            default:            state_d = trq_pkg::S_IDLE;
          endcase
        end
      end

      trq_pkg::S_READ: begin
        state_d = (idx_q == count_q) ? trq_pkg::S_FIN : trq_pkg::S_EVAL;
      end

      trq_pkg::S_EVAL: begin
        unique case (func_q)
          trq_pkg::FN_ENQUEUE: begin
            if (cmp_res.key_match) begin
              found_d = 1'b1;
            end
            idx_d   = idx_q + 1'b1;
            state_d = trq_pkg::S_READ;
          end
          trq_pkg::FN_CANCEL: begin
            if (cmp_res.key_match && !found_q) begin
              found_d = 1'b1;
            end else begin
              ram_we = 1'b1;
              wr_d   = wr_q + 1'b1;
            end
            idx_d   = idx_q + 1'b1;
            state_d = trq_pkg::S_READ;
          end
          trq_pkg::FN_NEWBLOCK: begin
            if (cmp_res.ready) begin
              if (!pend_valid_q || out_free) begin
                if (pend_valid_q) begin
                  out_load     = 1'b1;
                  out_status_d = trq_pkg::ST_RELEASED;
                  out_slot_d   = pend_q;
                  out_last_d   = 1'b0;
                end
                pend_d       = ram_rdata;
                pend_valid_d = 1'b1;
                idx_d        = idx_q + 1'b1;
                state_d      = trq_pkg::S_READ;
              end
            end else begin
              ram_we  = 1'b1;
              wr_d    = wr_q + 1'b1;
              idx_d   = idx_q + 1'b1;
              state_d = trq_pkg::S_READ;
            end
          end
          default: state_d = trq_pkg::S_IDLE;
        endcase
      end

      trq_pkg::S_FIN: begin
        unique case (func_q)
          trq_pkg::FN_ENQUEUE: begin
            state_d = trq_pkg::S_RESP;
            priority if (found_q) begin
              status_d = trq_pkg::ST_DUPLICATE;
            end else if (count_q == trq_pkg::CW'(trq_pkg::DEPTH)) begin
              status_d = trq_pkg::ST_FULL;
            end else begin
              status_d            = trq_pkg::ST_QUEUED;
              ram_we              = 1'b1;
              ram_waddr           = count_q[trq_pkg::IW-1:0];
              ram_wdata.key       = key_q;
              ram_wdata.handle    = handle_q;
              ram_wdata.by_height = by_height_q;
              ram_wdata.trigger   = trig_q;
              count_d             = count_q + 1'b1;
            end
          end
          trq_pkg::FN_CANCEL: begin
            count_d  = wr_q;
            status_d = found_q ? trq_pkg::ST_CANCELLED : trq_pkg::ST_NOT_FOUND;
            state_d  = trq_pkg::S_RESP;
          end
          trq_pkg::FN_NEWBLOCK: begin
            count_d = wr_q;
            if (!pend_valid_q) begin
              status_d = trq_pkg::ST_NONE_READY;
              state_d  = trq_pkg::S_RESP;
            end else if (out_free) begin
              out_load     = 1'b1;
              out_status_d = trq_pkg::ST_RELEASED;
              out_slot_d   = pend_q;
              out_last_d   = 1'b1;
              pend_valid_d = 1'b0;
              state_d      = trq_pkg::S_IDLE;
            end
          end
          default: state_d = trq_pkg::S_IDLE;
        endcase
      end

      trq_pkg::S_RESP: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_status_d = status_q;
          out_slot_d   = '0;
          out_last_d   = 1'b1;
          state_d      = trq_pkg::S_IDLE;
        end
      end

      default: state_d = trq_pkg::S_IDLE;
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (m_axis_tready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= trq_pkg::S_IDLE;
      idx_q        <= '0;
      wr_q         <= '0;
      count_q      <= '0;
      found_q      <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      wr_q         <= wr_d;
      count_q      <= count_d;
      found_q      <= found_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q       <= pend_d;
    func_q       <= func_d;
    key_q        <= key_d;
    handle_q     <= handle_d;
    by_height_q  <= by_height_d;
    trig_q       <= trig_d;
    ch_q         <= ch_d;
    ct_q         <= ct_d;
    status_q     <= status_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_last_q   <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {{(trq_pkg::OUT_TDATA_W - $bits(trq_pkg::slot_t)){1'b0}},
                            out_slot_q};

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= trq_pkg::CW'(trq_pkg::DEPTH))
    else $error("entry count beyond table depth");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || m_axis_tready_i))
    else $error("result register overwritten while stalled");

  a_compact_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_q <= idx_q)
    else $error("compaction write index ahead of read index");

  a_eval_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == trq_pkg::S_EVAL) |-> (idx_q < count_q))
    else $error("entry evaluated beyond the filled part of the table");

endmodule

>>> rtl/trq_ram.sv
// Generic single write port RAM with registered read.
module trq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/trq_cmp.sv
// Shared compare unit: key match and trigger readiness of one stored entry.
module trq_cmp (
  input  logic                  [63:0] key_i,
  input  logic signed           [31:0] chain_height_i,
  input  logic signed           [63:0] chain_time_i,
  input  trq_pkg::slot_t               slot_i,
  output trq_pkg::cmp_res_t            res_o
);

  logic signed [63:0] chain_val;

  assign chain_val = slot_i.by_height ? {{32{chain_height_i[31]}}, chain_height_i}
                                      : chain_time_i;

  assign res_o.key_match = (slot_i.key == key_i);
  assign res_o.ready     = (chain_val >= $signed(slot_i.trigger));

endmodule

>>> test/triggered_release_queue_tb.sv
// Self-checking testbench of the triggered release queue: directed and random operations.
module triggered_release_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FN_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int N_RANDOM = 393;
  localparam int KEY_POOL = 24;

  typedef struct {
    logic [1:0]         func;
    logic [63:0]        key;
    logic [31:0]        handle;
    logic               has_h;
    logic               has_t;
    logic signed [31:0] hval;
    logic signed [63:0] tval;
    logic signed [31:0] ch;
    logic signed [63:0] ct;
    bit                 hold;
  } op_t;

  typedef struct {
    trq_pkg::status_e   status;
    logic [63:0]        key;
    logic [31:0]        handle;
    logic               by_h;
    logic signed [63:0] trig;
    logic               last;
  } result_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [trq_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  logic [1:0]                      s_tuser = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [trq_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic [3:0]                      m_tuser;
  logic                            m_tlast;

  // shadow copy of the entry table
  logic [63:0]        tbl_key[trq_pkg::DEPTH];
  logic [31:0]        tbl_handle[trq_pkg::DEPTH];
  logic               tbl_byh[trq_pkg::DEPTH];
  logic signed [63:0] tbl_trig[trq_pkg::DEPTH];
  int                 tbl_count = 0;

  op_t         pending[$];
  result_t     results_due[$];
  op_t         cur_op;
  result_t     want;
  logic [63:0] key_pool[KEY_POOL];
  int          hgen;
  longint      tgen;
  int          s_gap = 0;
  bit          s_quiet = 1'b0;
  int          m_stall = 0;
  bit          m_quiet = 1'b0;
  int          stuck_cycles = 0;
  int          n_errors = 0;
  int          n_ops[4] = '{0, 0, 0, 0};
  int          n_released = 0;
  int          n_full = 0;

  triggered_release_queue dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  always #10 clk_i = ~clk_i;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, KEY_POOL - 1)];
    return {$urandom, $urandom};
  endfunction

  function automatic result_t status_only(trq_pkg::status_e st);
    result_t r;
    r.status = st;
    r.key    = '0;
    r.handle = '0;
    r.by_h   = 1'b0;
    r.trig   = '0;
    r.last   = 1'b1;
    return r;
  endfunction

  // unused fields carry random bits
  function automatic op_t base_op(logic [1:0] f, logic [63:0] k);
    op_t op;
    op.func   = f;
    op.key    = k;
    op.handle = $urandom;
    op.has_h  = 1'($urandom_range(0, 1));
    op.has_t  = 1'($urandom_range(0, 1));
    op.hval   = $urandom;
    op.tval   = {$urandom, $urandom};
    op.ch     = $urandom;
    op.ct     = {$urandom, $urandom};
    op.hold   = 1'b0;
    return op;
  endfunction

  function automatic op_t enq_op(logic [63:0] k, bit by_h, logic signed [63:0] v);
    op_t op;
    op = base_op(trq_pkg::FN_ENQUEUE, k);
    op.has_h = by_h;
    op.has_t = !by_h;
    if (by_h) op.hval = v[31:0];
    else op.tval = v;
    return op;
  endfunction

  function automatic op_t random_op();
    op_t op;
    int  sel;
    int  r;
    sel = $urandom_range(0, 99);
    r   = $urandom_range(0, 99);
    if (sel < 50) begin
      if (r < 80) begin
        if ($urandom_range(0, 1)) begin
          op = enq_op(pick_key(), 1'b1, 64'(hgen + $urandom_range(0, 12)));
        end else begin
          op = enq_op(pick_key(), 1'b0, 64'(tgen + $urandom_range(0, 3000)));
        end
      end else begin
        op = base_op(trq_pkg::FN_ENQUEUE, pick_key());
      end
    end else if (sel < 68) begin
      op = base_op(trq_pkg::FN_NEWBLOCK, {$urandom, $urandom});
      if (r < 85) begin
        hgen += $urandom_range(0, 6);
        tgen += $urandom_range(0, 1200);
        op.ch = hgen;
        op.ct = tgen;
      end
    end else if (sel < 96) begin
      op = base_op(trq_pkg::FN_CANCEL, pick_key());
    end else begin
      op = base_op(FN_UNUSED, {$urandom, $urandom});
    end
    return op;
  endfunction

  function automatic logic [trq_pkg::IN_TDATA_W-1:0] pack_op(op_t op);
    return {6'b0, op.ct, op.ch, op.tval, op.hval, op.has_t, op.has_h, op.handle, op.key};
  endfunction

  task automatic predict_results(input op_t op);
    result_t            rel[$];
    result_t            r;
    logic signed [63:0] ch64;
    int                 pos;
    int                 w;
    bit                 ready;
    trq_pkg::status_e   st;
    pos = -1;
    for (int i = 0; i < tbl_count; i++) begin
      if (pos < 0 && tbl_key[i] == op.key) pos = i;
    end
    case (op.func)
      trq_pkg::FN_ENQUEUE: begin
        if (!op.has_h && !op.has_t) st = trq_pkg::ST_NO_TRIGGER;
        else if (op.has_h && op.has_t) st = trq_pkg::ST_BOTH;
        else if ((op.has_h && op.hval < 0) || (op.has_t && op.tval < 0)) begin
          st = trq_pkg::ST_NEGATIVE;
        end
        else if (pos >= 0) st = trq_pkg::ST_DUPLICATE;
        else if (tbl_count >= trq_pkg::DEPTH) st = trq_pkg::ST_FULL;
        else begin
          tbl_key[tbl_count]    = op.key;
          tbl_handle[tbl_count] = op.handle;
          tbl_byh[tbl_count]    = op.has_h;
          tbl_trig[tbl_count]   = op.has_h ? {{32{op.hval[31]}}, op.hval} : op.tval;
          tbl_count++;
          st = trq_pkg::ST_QUEUED;
        end
        results_due = {results_due, status_only(st)};
      end
      trq_pkg::FN_NEWBLOCK: begin
        ch64 = {{32{op.ch[31]}}, op.ch};
        w = 0;
        for (int i = 0; i < tbl_count; i++) begin
          ready = tbl_byh[i] ? (ch64 >= tbl_trig[i]) : (op.ct >= tbl_trig[i]);
          if (ready) begin
            r.status = trq_pkg::ST_RELEASED;
            r.key    = tbl_key[i];
            r.handle = tbl_handle[i];
            r.by_h   = tbl_byh[i];
            r.trig   = tbl_trig[i];
            r.last   = 1'b0;
            rel = {rel, r};
          end else begin
            tbl_key[w]    = tbl_key[i];
            tbl_handle[w] = tbl_handle[i];
            tbl_byh[w]    = tbl_byh[i];
            tbl_trig[w]   = tbl_trig[i];
            w++;
          end
        end
        tbl_count = w;
        if (rel.size() == 0) begin
          results_due = {results_due, status_only(trq_pkg::ST_NONE_READY)};
        end else begin
          rel[rel.size() - 1].last = 1'b1;
          results_due = {results_due, rel};
        end
      end
      trq_pkg::FN_CANCEL: begin
        if (pos >= 0) begin
          for (int i = pos; i + 1 < tbl_count; i++) begin
            tbl_key[i]    = tbl_key[i + 1];
            tbl_handle[i] = tbl_handle[i + 1];
            tbl_byh[i]    = tbl_byh[i + 1];
            tbl_trig[i]   = tbl_trig[i + 1];
          end
          tbl_count--;
          results_due = {results_due, status_only(trq_pkg::ST_CANCELLED)};
        end else begin
          results_due = {results_due, status_only(trq_pkg::ST_NOT_FOUND)};
        end
      end
      default: ;
    endcase
  endtask

  // operation driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_results(cur_op);
        n_ops[cur_op.func]++;
      end
      if (!s_tvalid || s_tready) begin
        if (s_gap > 0) begin
          s_gap--;
          s_tvalid <= 1'b0;
        end else if (pending.size() > 0 && (!pending[0].hold || results_due.size() == 0)) begin
          cur_op = pending.pop_front();
          s_tdata  <= pack_op(cur_op);
          s_tuser  <= cur_op.func;
          s_tvalid <= 1'b1;
          if ($urandom_range(0, 49) == 0) s_quiet = !s_quiet;
          s_gap = s_quiet ? 0 : pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result backpressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) m_quiet = !m_quiet;
      if (m_stall > 0) begin
        m_stall--;
        m_tready <= 1'b0;
      end else if (!m_quiet && $urandom_range(0, 3) == 0) begin
        m_stall = pick_gap();
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      if (m_tuser == trq_pkg::ST_RELEASED) n_released++;
      if (m_tuser == trq_pkg::ST_FULL) n_full++;
      if (results_due.size() == 0) begin
        $error("result transaction with none expected, status %0d", m_tuser);
        n_errors++;
      end else begin
        want = results_due.pop_front();
        if (m_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tuser);
          n_errors++;
        end
        if (m_tdata[63:0] !== want.key) begin
          $error("out_key: expected %h, got %h", want.key, m_tdata[63:0]);
          n_errors++;
        end
        if (m_tdata[95:64] !== want.handle) begin
          $error("out_handle: expected %h, got %h", want.handle, m_tdata[95:64]);
          n_errors++;
        end
        if (m_tdata[96] !== want.by_h) begin
          $error("out_by_height: expected %0b, got %0b", want.by_h, m_tdata[96]);
          n_errors++;
        end
        if (m_tdata[160:97] !== want.trig) begin
          $error("out_trigger: expected %0d, got %0d", want.trig, $signed(m_tdata[160:97]));
          n_errors++;
        end
        if (m_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, m_tlast);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    wait (stuck_cycles >= WATCHDOG_LIMIT);
    $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    op_t op;
    for (int i = 0; i < KEY_POOL; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    hgen = $urandom_range(0, 2000000);
    tgen = {1'b0, 31'($urandom), 32'($urandom)};

    // empty table, most negative chain values
    op = base_op(trq_pkg::FN_NEWBLOCK, '0);
    op.ch = 32'h8000_0000;
    op.ct = 64'h8000_0000_0000_0000;
    pending = {pending, op};
    op = base_op(trq_pkg::FN_ENQUEUE, key_pool[0]);
    op.has_h = 1'b0;
    op.has_t = 1'b0;
    pending = {pending, op};
    op = base_op(trq_pkg::FN_ENQUEUE, key_pool[0]);
    op.has_h = 1'b1;
    op.has_t = 1'b1;
    pending = {pending, op};
    pending = {pending, enq_op(key_pool[0], 1'b1, 64'h8000_0000)};
    pending = {pending, enq_op(key_pool[0], 1'b0, -64'sd1)};
    op = enq_op(key_pool[0], 1'b1, 64'sd0);
    op.handle = '0;
    pending = {pending, op};
    pending = {pending, enq_op(key_pool[0], 1'b0, 64'sd5)};
    pending = {pending, base_op(trq_pkg::FN_CANCEL, 64'h5555_aaaa_5555_aaaa)};
    pending = {pending, base_op(FN_UNUSED, '1)};
    // fill the table to the brim, extreme triggers among the entries
    for (int i = 1; i < trq_pkg::DEPTH; i++) begin
      if (i == 1) op = enq_op(key_pool[1], 1'b1, 64'h7fff_ffff);
      else if (i == 2) op = enq_op(key_pool[2], 1'b0, 64'h7fff_ffff_ffff_ffff);
      else if (i == 4) op = enq_op(key_pool[4], 1'b0, 64'sd0);
      else op = enq_op(key_pool[i], 1'(i % 2), 64'(hgen + i));
      if (i == 3) op.handle = '1;
      pending = {pending, op};
    end
    pending = {pending, enq_op(key_pool[trq_pkg::DEPTH + 1], 1'b1, 64'sd7)};
    pending = {pending, base_op(trq_pkg::FN_CANCEL, key_pool[5])};
    op = base_op(trq_pkg::FN_NEWBLOCK, '1);
    op.ch = 32'h7fff_ffff;
    op.ct = 64'h7fff_ffff_ffff_ffff;
    op.hold = 1'b1;
    pending = {pending, op};

    for (int i = 0; i < N_RANDOM; i++) begin
      op = random_op();
      op.hold = (i % 100 == 50);
      pending = {pending, op};
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending.size() > 0 || s_tvalid) @(posedge clk_i);
    while (results_due.size() > 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    $display("Ran %0d enqueue, %0d new-block, %0d cancel and %0d unused-selector operations.",
             n_ops[trq_pkg::FN_ENQUEUE], n_ops[trq_pkg::FN_NEWBLOCK],
             n_ops[trq_pkg::FN_CANCEL], n_ops[FN_UNUSED]);
    $display("%0d entries released, %0d enqueues refused on a full table.", n_released, n_full);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> triggered_release_queue.f
rtl/trq_pkg.sv
rtl/trq_ram.sv
rtl/trq_cmp.sv
rtl/triggered_release_queue.sv
test/triggered_release_queue_tb.sv
